[sv/bvc_pkg.sv]
// Shared types, constants and helpers for the balance velocity controller.
// No dependencies; every other file depends on this package.
`default_nettype none

package bvc_pkg;

	// Field widths
	localparam int GAIN_W   = 24;
	localparam int ANGLE_W  = 17;
	localparam int RATE_W   = 20;
	localparam int COUNT_W  = 16;
	localparam int ILIM_W   = 20;
	localparam int TLIM_W   = 16;
	localparam int DRIVE_W  = 32;
	localparam int STATE_W  = 32;
	localparam int CFG_IDX_W = 3;

	// Q16 accumulator wide enough for any sum of two products
	localparam int ACC_W = 58;
	localparam int Q16_SHIFT = 16;
	typedef logic signed [ACC_W-1:0] acc_t;

	localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;

	// ceil(2^34 / 5): floor(m * RECIP5 / 2^34) == floor(m / 5) for m < 2^32
	localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
	localparam int RECIP5_SHIFT = 34;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UPRIGHT_KP     = 3'd0,
		REG_UPRIGHT_KD     = 3'd1,
		REG_SPEED_KP       = 3'd2,
		REG_SPEED_KI       = 3'd3,
		REG_BALANCE_ANGLE  = 3'd4,
		REG_INTEGRAL_LIMIT = 3'd5,
		REG_TILT_LIMIT     = 3'd6
	} reg_idx_t;

	localparam logic signed [GAIN_W-1:0]  UPRIGHT_KP_RST     = -24'sd61440;
	localparam logic signed [GAIN_W-1:0]  UPRIGHT_KD_RST     = -24'sd174;
	localparam logic signed [GAIN_W-1:0]  SPEED_KP_RST       = -24'sd34560;
	localparam logic signed [GAIN_W-1:0]  SPEED_KI_RST       = -24'sd172;
	localparam logic signed [ANGLE_W-1:0] BALANCE_ANGLE_RST  = 17'sd0;
	localparam logic [ILIM_W-1:0]         INTEGRAL_LIMIT_RST = 20'd10000;
	localparam logic [TLIM_W-1:0]         TILT_LIMIT_RST     = 16'd17408;

	typedef struct packed {
		logic signed [GAIN_W-1:0]  upright_kp;
		logic signed [GAIN_W-1:0]  upright_kd;
		logic signed [GAIN_W-1:0]  speed_kp;
		logic signed [GAIN_W-1:0]  speed_ki;
		logic signed [ANGLE_W-1:0] balance_angle;
		logic [ILIM_W-1:0]         integral_limit;
		logic [TLIM_W-1:0]         tilt_limit;
	} gains_t;

	// Classified request as it travels from front to back
	typedef struct packed {
		logic signed [ANGLE_W:0]   err;   // pitch - balance angle
		logic signed [RATE_W-1:0]  rate;
		logic signed [COUNT_W:0]   csum;  // left + right
		logic                      tilt;
	} entry_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_DONE
	} back_state_t;

	// Divide a Q16 sum by 65536 toward zero, then saturate to 32 bits
	function automatic logic signed [DRIVE_W-1:0] q16_to_drive(input acc_t s);
		acc_t q;
		q = s >>> Q16_SHIFT;
		if (s[ACC_W-1] && (s[Q16_SHIFT-1:0] != '0))
			q = q + acc_t'(1);
		if (q > acc_t'(DRIVE_MAX))
			return DRIVE_MAX;
		if (q < acc_t'(DRIVE_MIN))
			return DRIVE_MIN;
		return q[DRIVE_W-1:0];
	endfunction

endpackage

`default_nettype wire

[sv/bvc_if.sv]
// Channel interfaces: sensor request, drive result and configuration write.
// Depends on bvc_pkg for field widths.
`default_nettype none

interface bvc_sensor_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [bvc_pkg::ANGLE_W-1:0]    pitch_angle;
	logic signed [bvc_pkg::RATE_W-1:0]     pitch_rate;
	logic signed [bvc_pkg::COUNT_W-1:0]    left_count;
	logic signed [bvc_pkg::COUNT_W-1:0]    right_count;

	modport source (output valid, pitch_angle, pitch_rate, left_count, right_count,
		input ready);
	modport sink (input valid, pitch_angle, pitch_rate, left_count, right_count,
		output ready);
endinterface

interface bvc_drive_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [bvc_pkg::DRIVE_W-1:0]    upright_drive;
	logic signed [bvc_pkg::DRIVE_W-1:0]    speed_drive;
	logic                                  tilt_off;

	modport source (output valid, upright_drive, speed_drive, tilt_off, input ready);
	modport sink (input valid, upright_drive, speed_drive, tilt_off, output ready);
endinterface

interface bvc_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [bvc_pkg::CFG_IDX_W-1:0]         index;
	logic [bvc_pkg::GAIN_W-1:0]            data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/bvc_front.sv]
// Front end: accept sensor requests, form pitch error, encoder sum and tilt flag.
// Depends on bvc_pkg and bvc_sensor_if.
`default_nettype none

module bvc_front (
	bvc_sensor_if.sink       sensor,
	input  bvc_pkg::gains_t  gains,
	input  logic             full,
	output logic             push,
	output bvc_pkg::entry_t  ent
);
	import bvc_pkg::*;

	logic signed [ANGLE_W:0] pitch_x;
	logic signed [ANGLE_W:0] tlim_pos;
	logic signed [ANGLE_W:0] tlim_neg;

	assign sensor.ready = !full;
	assign push = sensor.valid && !full;

	always_comb begin
		pitch_x  = (ANGLE_W+1)'(sensor.pitch_angle);
		tlim_pos = $signed({2'b00, gains.tilt_limit});
		tlim_neg = -tlim_pos;
		ent.err  = pitch_x - (ANGLE_W+1)'(gains.balance_angle);
		ent.rate = sensor.pitch_rate;
		ent.csum = (COUNT_W+1)'(sensor.left_count) + (COUNT_W+1)'(sensor.right_count);
		ent.tilt = (pitch_x > tlim_pos) || (pitch_x < tlim_neg);
	end

endmodule

`default_nettype wire

[sv/bvc_queue.sv]
// Two-entry queue between front and back end.
// Depends on bvc_pkg for the entry type.
`default_nettype none

module bvc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bvc_pkg::entry_t  push_ent,
	output logic             full,
	input  logic             pop,
	output bvc_pkg::entry_t  pop_ent,
	output logic             empty
);
	import bvc_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign pop_ent = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/bvc_back.sv]
// Back end: sequenced PD and PI arithmetic, speed state and output register.
// Depends on bvc_pkg and bvc_drive_if.
`default_nettype none

module bvc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bvc_pkg::gains_t  gains,
	input  logic             empty,
	input  bvc_pkg::entry_t  pop_ent,
	output logic             pop,
	bvc_drive_if.source      drive
);
	import bvc_pkg::*;

	back_state_t state_q, state_d;
	logic        finish;

	entry_t                    e_q;
	logic [31:0]               mag_q;
	logic                      neg_q;
	logic signed [41:0]        up_p0_q;
	logic signed [43:0]        up_p1_q;
	logic [63:0]               rq_q;
	logic signed [DRIVE_W-1:0] up_q;
	logic signed [STATE_W-1:0] filt_q;
	logic signed [STATE_W-1:0] integ_q;
	logic signed [55:0]        sp_p0_q;
	logic signed [55:0]        sp_p1_q;

	logic signed [STATE_W-1:0] fs_q;
	logic signed [STATE_W-1:0] si_q;

	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] out_up_q;
	logic signed [DRIVE_W-1:0] out_sp_q;
	logic                      out_tilt_q;

	logic signed [34:0]        num;
	logic signed [34:0]        num_abs;
	logic [29:0]               quo;
	logic signed [STATE_W-1:0] filt;
	logic signed [32:0]        integ_sum;
	logic signed [32:0]        lim_pos;
	logic signed [32:0]        lim_neg;
	logic signed [32:0]        integ_clamp;
	acc_t                      up_sum;
	acc_t                      sp_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		finish  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || drive.ready) begin
					finish  = 1'b1;
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Filter numerator 4*old + 256*sum; its magnitude stays below 2^27 from reset on
	always_comb begin
		num     = {fs_q[STATE_W-1], fs_q, 2'b00} + {{10{pop_ent.csum[COUNT_W]}}, pop_ent.csum, 8'b0};
		num_abs = num[34] ? -num : num;
	end

	always_comb begin
		quo         = rq_q[63:RECIP5_SHIFT];
		filt        = neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
		integ_sum   = 33'(si_q) + 33'(filt);
		lim_pos     = $signed({5'b00000, gains.integral_limit, 8'b0});
		lim_neg     = -lim_pos;
		integ_clamp = integ_sum;
		if (integ_sum > lim_pos)
			integ_clamp = lim_pos;
		if (integ_sum < lim_neg)
			integ_clamp = lim_neg;
		up_sum = acc_t'(up_p0_q) + acc_t'(up_p1_q);
		sp_sum = acc_t'(sp_p0_q) + acc_t'(sp_p1_q);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (pop) begin
					e_q   <= pop_ent;
					mag_q <= num_abs[31:0];
					neg_q <= num[34];
				end
			end
			ST_MUL1: begin
				up_p0_q <= e_q.err * gains.upright_kp;
				up_p1_q <= e_q.rate * gains.upright_kd;
				rq_q    <= mag_q * RECIP5;
			end
			ST_MUL2: begin
				up_q    <= q16_to_drive(up_sum);
				filt_q  <= filt;
				integ_q <= integ_clamp[STATE_W-1:0];
			end
			ST_MUL3: begin
				sp_p0_q <= filt_q * gains.speed_kp;
				sp_p1_q <= integ_q * gains.speed_ki;
			end
			default: begin
			end
		endcase
		if (finish) begin
			out_up_q   <= up_q;
			out_sp_q   <= q16_to_drive(sp_sum);
			out_tilt_q <= e_q.tilt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q        <= '0;
			si_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				fs_q        <= filt_q;
				si_q        <= e_q.tilt ? '0 : integ_q;
				out_valid_q <= 1'b1;
			end else if (drive.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign drive.valid         = out_valid_q;
	assign drive.upright_drive = out_up_q;
	assign drive.speed_drive   = out_sp_q;
	assign drive.tilt_off      = out_tilt_q;

endmodule

`default_nettype wire

[sv/balance_velocity_controller.sv]
// Top level of the cascaded balance controller: register bank, front, queue, back.
// Depends on bvc_pkg, bvc_if, bvc_front, bvc_queue and bvc_back.
//
//   channel  role  carries
//   -------  ----  -------------------------------------------------------------
//   sensor   sink  pitch_angle, pitch_rate, left_count, right_count per tick
//   drive    src   upright_drive, speed_drive, tilt_off, one per request
//   cfg      sink  register index and write data, always ready
//
// The front takes a request whenever the two-entry queue has room.
// The back takes each request through load, upright and filter products, PD sum
// with filter and integral clamp, PI products and PI sum, and pops the next one
// only after that, since the filter and integral of one tick feed the next.
// Reset returns the gains to their defaults and clears filter and integral state.
// A stalled drive channel holds the result; the back waits in its last step and
// the queue absorbs up to two more requests before sensor.ready drops.
`default_nettype none

module balance_velocity_controller (
	input  logic        clk,
	input  logic        arst_n,
	bvc_sensor_if.sink  sensor,
	bvc_drive_if.source drive,
	bvc_cfg_if.sink     cfg
);
	import bvc_pkg::*;

	gains_t gains_q;
	entry_t push_ent;
	entry_t pop_ent;
	logic   push;
	logic   pop;
	logic   full;
	logic   empty;

	// Configuration writes land at once; an unknown index is dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.upright_kp     <= UPRIGHT_KP_RST;
			gains_q.upright_kd     <= UPRIGHT_KD_RST;
			gains_q.speed_kp       <= SPEED_KP_RST;
			gains_q.speed_ki       <= SPEED_KI_RST;
			gains_q.balance_angle  <= BALANCE_ANGLE_RST;
			gains_q.integral_limit <= INTEGRAL_LIMIT_RST;
			gains_q.tilt_limit     <= TILT_LIMIT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_UPRIGHT_KP:     gains_q.upright_kp     <= cfg.data;
				REG_UPRIGHT_KD:     gains_q.upright_kd     <= cfg.data;
				REG_SPEED_KP:       gains_q.speed_kp       <= cfg.data;
				REG_SPEED_KI:       gains_q.speed_ki       <= cfg.data;
				REG_BALANCE_ANGLE:  gains_q.balance_angle  <= cfg.data[ANGLE_W-1:0];
				REG_INTEGRAL_LIMIT: gains_q.integral_limit <= cfg.data[ILIM_W-1:0];
				REG_TILT_LIMIT:     gains_q.tilt_limit     <= cfg.data[TLIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Classify each request: pitch error, encoder sum, tilt flag
	bvc_front u_front (
		.sensor (sensor),
		.gains  (gains_q),
		.full   (full),
		.push   (push),
		.ent    (push_ent)
	);

	// Decouple front and back so each can stall on its own
	bvc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.full     (full),
		.pop      (pop),
		.pop_ent  (pop_ent),
		.empty    (empty)
	);

	// Run the PD and PI arithmetic and hold the result for the drive channel
	bvc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.gains   (gains_q),
		.empty   (empty),
		.pop_ent (pop_ent),
		.pop     (pop),
		.drive   (drive)
	);

endmodule

`default_nettype wire
